// ===== rtl/pkrl_pkg.sv =====
// Shared widths, word layouts and types of the per-key recency list.
package pkrl_pkg;

   localparam int STATION_W   = 16;
   localparam int VEHICLE_W   = 8;
   localparam int POS_OUT_W   = 4;
   localparam int REQ_TDATA_W = 24;   // vehicle, station
   localparam int RSP_TDATA_W = 40;   // entry_station, position, dropped_station, pad
   localparam int RSP_TUSER_W = 2;    // ignored, dropped_valid

   typedef struct packed {
      logic                 valid;
      logic [STATION_W-1:0] station;
   } pkrl_drop_type;

endpackage

// ===== rtl/per_key_recency_list.sv =====
// Top level: per-vehicle most-recently-used station lists held in one row memory.
//
// req channel: one word per visit (vehicle, station). rsp channel: the vehicle's
// updated list, newest first, one word per entry, tlast on the final word; the
// eviction flag and evicted station repeat on every word of that list. A
// vehicle id at or above VEHICLES leaves all lists untouched and yields a
// single word with the ignored flag set.
// Timing: the row read for a taken word returns in the next cycle, where it
// is updated and written back; results then leave at one word per cycle while
// rsp_tready is high. The next request is taken together with the final
// result word.
// Reset: a clearing pass zeroes every list length; req_tready stays low
// meanwhile. A stalled rsp_tready holds the current result word and no new
// request is taken until the final word leaves.
module per_key_recency_list
   import pkrl_pkg::*;
#(
   parameter int VEHICLES = 128,
   parameter int CAPACITY = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // vehicle[7:0], station[23:8]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // entry_station[15:0], position[19:16],
                                               // dropped_station[35:20], zero[39:36]
   output logic                   rsp_tlast,
   output logic [RSP_TUSER_W-1:0] rsp_tuser    // ignored[0], dropped_valid[1]
);

   localparam int VIDX_W = (VEHICLES > 1) ? $clog2(VEHICLES) : 1;
   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int POS_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int ROW_W  = CAPACITY * STATION_W;
   localparam int MEM_W  = ROW_W + LEN_W;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [VIDX_W-1:0]    clr_ff, clr_in;
   logic [VIDX_W-1:0]    veh_ff, veh_in;
   logic [STATION_W-1:0] st_ff, st_in;
   logic                 ign_ff, ign_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   pkrl_drop_type        drop_ff, drop_in;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 is_last;
   logic [VIDX_W-1:0]    req_vidx;
   logic                 req_ign;

   logic                 wr_en;
   logic [VIDX_W-1:0]    wr_addr;
   logic [MEM_W-1:0]     wr_data;
   logic [MEM_W-1:0]     rd_data;

   logic [ROW_W-1:0]     upd_row;
   logic [LEN_W-1:0]     upd_len;
   pkrl_drop_type        upd_drop;
   logic [STATION_W-1:0] entry_station;

   assign req_vidx = VIDX_W'(req_tdata[VEHICLE_W-1:0]);
   assign req_ign  = 32'(req_tdata[VEHICLE_W-1:0]) >= 32'(VEHICLES);
   assign is_last  = (LEN_W'(pos_ff) + LEN_W'(1)) == cnt_ff;

   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   // next word may enter while the final result word leaves
   assign req_tready = (state_ff == ST_IDLE) ||
                       ((state_ff == ST_EMIT) && is_last && rsp_tready);
   assign req_fire   = req_tvalid & req_tready;

   pkrl_ram #(
      .WIDTH (MEM_W),
      .DEPTH (VEHICLES)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_vidx),
      .rd_data (rd_data)
   );

   pkrl_row_update #(
      .CAPACITY (CAPACITY)
   ) u_row_update (
      .row     (rd_data[ROW_W-1:0]),
      .len     (rd_data[MEM_W-1:ROW_W]),
      .station (st_ff),
      .new_row (upd_row),
      .new_len (upd_len),
      .drop    (upd_drop)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = veh_ff;
      wr_data = {upd_len, upd_row};
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if ((state_ff == ST_UPDATE) && !ign_ff) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      veh_in   = veh_ff;
      st_in    = st_ff;
      ign_in   = ign_ff;
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      drop_in  = drop_ff;

      if (req_fire) begin
         veh_in = req_vidx;
         st_in  = req_tdata[VEHICLE_W +: STATION_W];
         ign_in = req_ign;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + VIDX_W'(1);
            if (clr_ff == VIDX_W'(VEHICLES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            pos_in   = '0;
            state_in = ST_EMIT;
            if (ign_ff) begin
               cnt_in  = LEN_W'(1);
               drop_in = '0;
            end else begin
               row_in  = upd_row;
               cnt_in  = upd_len;
               drop_in = upd_drop;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (is_last) begin
                  state_in = req_fire ? ST_UPDATE : ST_IDLE;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      veh_ff  <= veh_in;
      st_ff   <= st_in;
      ign_ff  <= ign_in;
      row_ff  <= row_in;
      cnt_ff  <= cnt_in;
      drop_ff <= drop_in;
   end

   assign entry_station = ign_ff ? '0 : row_ff[pos_ff*STATION_W +: STATION_W];

   assign rsp_tdata = {{(RSP_TDATA_W - 2*STATION_W - POS_OUT_W){1'b0}},
                       drop_ff.station,
                       ign_ff ? POS_OUT_W'(0) : POS_OUT_W'(pos_ff),
                       entry_station};
   assign rsp_tlast = is_last;
   assign rsp_tuser = {drop_ff.valid, ign_ff};

   // no request is taken during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken while clearing");

   // row memory is never read and written in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && req_fire))
      else $error("row memory read and write overlap");

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_UPDATE))
      else $error("accepted word not followed by update");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((cnt_ff != '0) && (cnt_ff <= LEN_W'(CAPACITY))))
      else $error("result count out of range");

   // eviction only from a full list
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && drop_ff.valid) |-> (cnt_ff == LEN_W'(CAPACITY)))
      else $error("eviction reported on a list that is not full");

endmodule

// ===== rtl/pkrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pkrl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/pkrl_row_update.sv =====
// Move-to-front update of one vehicle row: parallel match, shift, eviction.
module pkrl_row_update
   import pkrl_pkg::*;
#(
   parameter int CAPACITY = 5,
   localparam int LEN_W = $clog2(CAPACITY + 1),
   localparam int ROW_W = CAPACITY * STATION_W
) (
   input  logic [ROW_W-1:0]     row,
   input  logic [LEN_W-1:0]     len,
   input  logic [STATION_W-1:0] station,
   output logic [ROW_W-1:0]     new_row,
   output logic [LEN_W-1:0]     new_len,
   output pkrl_drop_type        drop
);

   logic [LEN_W-1:0] len_c;
   logic [LEN_W-1:0] hit;
   logic             found;

   always_comb begin
      len_c = (len > LEN_W'(CAPACITY)) ? LEN_W'(CAPACITY) : len;

      // lowest matching slot wins
      found = 1'b0;
      hit   = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if ((LEN_W'(i) < len_c) && (row[i*STATION_W +: STATION_W] == station)) begin
            found = 1'b1;
            hit   = LEN_W'(i);
         end
      end

      drop    = '0;
      new_len = len_c;
      if (!found) begin
         if (len_c == LEN_W'(CAPACITY)) begin
            drop.valid   = 1'b1;
            drop.station = row[(CAPACITY-1)*STATION_W +: STATION_W];
            hit          = LEN_W'(CAPACITY - 1);
         end else begin
            hit     = len_c;
            new_len = len_c + LEN_W'(1);
         end
      end

      new_row[STATION_W-1:0] = station;
      for (int i = 1; i < CAPACITY; i++) begin
         new_row[i*STATION_W +: STATION_W] = (LEN_W'(i) <= hit)
            ? row[(i-1)*STATION_W +: STATION_W]
            : row[i*STATION_W +: STATION_W];
      end
   end

endmodule
